/* sv/pku_pkg.sv */
// Package for the PKCS#7 unpadding checker.
// Holds the sizing constants, register reset value and sequencer state type.
// No dependencies.
package pku_pkg;

    // Largest supported cipher block, in bytes
    localparam int MAX_BLOCK  = 32;
    // Bytes held back at most: one block less the final byte
    localparam int HOLD_DEPTH = MAX_BLOCK - 1;
    // Hold count must reach HOLD_DEPTH itself
    localparam int CNT_W      = $clog2(MAX_BLOCK);
    // Address into the hold buffer
    localparam int ADDR_W     = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

    // Block size register
    localparam int               CFG_W          = 6;
    localparam logic [CFG_W-1:0] BLOCK_SIZE_RST = CFG_W'(16);

    // Payload widths
    localparam int BYTE_W = 8;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,     // taking bytes
        ST_CHECK,    // reading held pad bytes for comparison
        ST_CHKWAIT,  // last comparison read returning
        ST_EMIT,     // draining held data bytes
        ST_STATUS    // closing status request
    } t_state;

endpackage

/* sv/pku_stream_if.sv */
// Valid/ready stream interfaces for the unpadding checker.
// pku_in_if carries padded message bytes, pku_out_if the unpadded result.
// Depends on pku_pkg for payload widths.
interface pku_in_if
    import pku_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface pku_out_if
    import pku_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              end_of_message;
    logic              pad_valid;

    modport source (output valid, output out_byte, output end_of_message,
                    output pad_valid, input ready);
    modport sink   (input valid, input out_byte, input end_of_message,
                    input pad_valid, output ready);
endinterface

/* sv/pku_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Read-first: a read and write to the same address return the old data.
// No dependencies.
module pku_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 31
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Storage and registered read; read data holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/pkcs7_unpad_checker.sv */
// PKCS#7 unpadding checker, top level.
// Depends on pku_pkg, pku_stream_if (pku_in_if, pku_out_if) and pku_ram.
//
// Usage:
//   i_in  : padded message bytes, in_last marks the final byte.
//   o_out : unpadded bytes, then one status request with end_of_message = 1
//           and pad_valid telling whether the padding was correct. On a bad
//           pad only the status follows, and bytes already sent are dropped
//           by the consumer.
//   i_cfg_wr_en / i_cfg_wr_data : block size (1..32), written while idle.
// The last block_size-1 bytes are held in a circular buffer in a RAM. While
// that buffer fills, bytes give no output; once full, each byte pushes the
// oldest held byte out through the RAM read register and the output register,
// one byte per cycle while o_out does not stall. A final byte that passes the
// length screen starts x-1 RAM reads to compare the pad bytes and a wait for
// the last read; if the pad matched, one read per held data byte; then status.
// All rates are bounded by the single RAM read port.
// Reset (synchronous, active low) empties the buffer, idles the sequencer and
// sets the block size to 16; no clearing pass is needed.
// A stall on o_out holds the output register; input is refused until a
// pending RAM read has been moved into it.
module pkcs7_unpad_checker
    import pku_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    pku_in_if.sink           i_in,
    pku_out_if.source        o_out,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data
);

    // Physical address of a logical offset from the buffer head
    function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] base,
                                                    input logic [CNT_W-1:0]  ofs);
        logic [ADDR_W:0] sum;
        sum = (ADDR_W + 1)'(base) + (ADDR_W + 1)'(ofs);
        if (sum >= (ADDR_W + 1)'(HOLD_DEPTH)) begin
            sum = sum - (ADDR_W + 1)'(HOLD_DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    // Control registers
    t_state             r_state,      n_state;
    logic [CFG_W-1:0]   r_block_size, n_block_size;
    logic [CNT_W-1:0]   r_count,      n_count;
    logic [ADDR_W-1:0]  r_head,       n_head;
    logic               r_pend,       n_pend;      // read in flight, bound for output
    logic               r_cmp_pend,   n_cmp_pend;  // read in flight, bound for compare
    logic               r_ov,         n_ov;
    // Working registers
    logic               r_ok,         n_ok;
    logic [BYTE_W-1:0]  r_x,          n_x;
    logic [CNT_W-1:0]   r_start,      n_start;
    logic [CNT_W-1:0]   r_idx,        n_idx;
    // Output payload
    logic [BYTE_W-1:0]  r_ob,         n_ob;
    logic               r_oe,         n_oe;
    logic               r_op,         n_op;

    // RAM port signals
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [BYTE_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [BYTE_W-1:0]  ram_rdata;

    logic               pend_done;
    logic               out_free;
    logic               in_ready;
    logic               in_fire;
    logic [CNT_W-1:0]   lim;
    logic [8:0]         x_ext;
    logic [8:0]         cnt_p1;
    logic               pad_fail;

    pku_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (HOLD_DEPTH)
    ) u_hold_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Handshake terms
    assign out_free  = !r_ov || o_out.ready;
    assign pend_done = r_pend && out_free;
    assign in_ready  = (r_state == ST_IDLE) && (!r_pend || pend_done) && out_free;
    assign in_fire   = i_in.valid && in_ready;

    assign i_in.ready           = in_ready;
    assign o_out.valid          = r_ov;
    assign o_out.out_byte       = r_ob;
    assign o_out.end_of_message = r_oe;
    assign o_out.pad_valid      = r_op;

    // Hold limit: block size clamped to 1..MAX_BLOCK, less one
    always_comb begin
        if (r_block_size == '0) begin
            lim = '0;
        end else if (int'(r_block_size) > MAX_BLOCK) begin
            lim = CNT_W'(HOLD_DEPTH);
        end else begin
            lim = CNT_W'(r_block_size - CFG_W'(1));
        end
    end

    // Pad length screen on the final byte
    assign x_ext    = 9'(i_in.in_byte);
    assign cnt_p1   = 9'(r_count) + 9'd1;
    assign pad_fail = (x_ext == 9'd0) || (x_ext > 9'(r_block_size)) || (x_ext > cnt_p1);

    // Sequencer, buffer pointers and output register loading
    always_comb begin
        n_state      = r_state;
        n_block_size = r_block_size;
        n_count      = r_count;
        n_head       = r_head;
        n_pend       = r_pend;
        n_cmp_pend   = 1'b0;
        n_ov         = r_ov;
        n_ok         = r_ok;
        n_x          = r_x;
        n_start      = r_start;
        n_idx        = r_idx;
        n_ob         = r_ob;
        n_oe         = r_oe;
        n_op         = r_op;
        ram_we       = 1'b0;
        ram_waddr    = phys_addr(r_head, r_count);
        ram_wdata    = i_in.in_byte;
        ram_re       = 1'b0;
        ram_raddr    = phys_addr(r_head, r_idx);

        if (i_cfg_wr_en) begin
            n_block_size = i_cfg_wr_data;
        end

        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        // Returning read bound for the output register
        if (pend_done) begin
            n_ob   = ram_rdata;
            n_oe   = 1'b0;
            n_op   = 1'b0;
            n_ov   = 1'b1;
            n_pend = 1'b0;
        end

        // Returning read bound for the pad comparison
        if (r_cmp_pend) begin
            n_ok = r_ok && (ram_rdata == r_x);
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (!i_in.in_last) begin
                        priority if (r_count < lim) begin
                            // still filling: append
                            ram_we  = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end else if (r_count == '0) begin
                            // nothing held: pass straight through
                            n_ob = i_in.in_byte;
                            n_oe = 1'b0;
                            n_op = 1'b0;
                            n_ov = 1'b1;
                        end else begin
                            // push oldest out, new byte in at the tail
                            ram_we    = 1'b1;
                            ram_re    = 1'b1;
                            ram_raddr = r_head;
                            n_pend    = 1'b1;
                            n_head    = phys_addr(r_head, CNT_W'(1));
                        end
                    end else begin
                        n_x     = i_in.in_byte;
                        n_start = CNT_W'(cnt_p1 - x_ext);
                        n_idx   = CNT_W'(cnt_p1 - x_ext);
                        priority if (pad_fail) begin
                            n_ok    = 1'b0;
                            n_state = ST_STATUS;
                        end else if (i_in.in_byte == BYTE_W'(1)) begin
                            // only the final byte is padding
                            n_ok  = 1'b1;
                            n_idx = '0;
                            if (r_count == '0) begin
                                n_state = ST_STATUS;
                            end else begin
                                n_state = ST_EMIT;
                            end
                        end else begin
                            n_ok    = 1'b1;
                            n_state = ST_CHECK;
                        end
                    end
                end
            end

            ST_CHECK: begin
                ram_re     = 1'b1;
                n_cmp_pend = 1'b1;
                n_idx      = r_idx + CNT_W'(1);
                if (r_idx == r_count - CNT_W'(1)) begin
                    n_state = ST_CHKWAIT;
                end
            end

            ST_CHKWAIT: begin
                n_idx = '0;
                if (!(r_ok && (ram_rdata == r_x)) || (r_start == '0)) begin
                    n_state = ST_STATUS;
                end else begin
                    n_state = ST_EMIT;
                end
            end

            ST_EMIT: begin
                if (!r_pend || pend_done) begin
                    ram_re = 1'b1;
                    n_pend = 1'b1;
                    n_idx  = r_idx + CNT_W'(1);
                    if (r_idx == r_start - CNT_W'(1)) begin
                        n_state = ST_STATUS;
                    end
                end
            end

            ST_STATUS: begin
                if (!r_pend && out_free) begin
                    n_ob    = '0;
                    n_oe    = 1'b1;
                    n_op    = r_ok;
                    n_ov    = 1'b1;
                    n_count = '0;
                    n_head  = '0;
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_block_size <= BLOCK_SIZE_RST;
            r_count      <= '0;
            r_head       <= '0;
            r_pend       <= 1'b0;
            r_cmp_pend   <= 1'b0;
            r_ov         <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_block_size <= n_block_size;
            r_count      <= n_count;
            r_head       <= n_head;
            r_pend       <= n_pend;
            r_cmp_pend   <= n_cmp_pend;
            r_ov         <= n_ov;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_ok    <= n_ok;
        r_x     <= n_x;
        r_start <= n_start;
        r_idx   <= n_idx;
        r_ob    <= n_ob;
        r_oe    <= n_oe;
        r_op    <= n_op;
    end

endmodule

/* test/tb.sv */
// Self-checking testbench for pkcs7_unpad_checker: random and directed messages
// against a cycle-free model of the unpadding and pad check.
// Depends on pku_pkg and the pku_in_if / pku_out_if stream interfaces.
module tb;
    import pku_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RST_CYCLES   = 8;
    localparam int DRAIN_CYCLES = 40;
    localparam int QUIET_LIMIT  = 2000;
    localparam int GAP_MAX      = 17;
    localparam int PHASE_ITEMS  = 48;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
        int                gap;
    } t_in_req;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              eom;
        logic              ok;
    } t_out_req;

    typedef enum logic [1:0] {
        MSG_GOOD,       // well-formed padding
        MSG_SPOILT,     // one pad byte altered
        MSG_BAD_VALUE,  // final byte zero, too large or arbitrary
        MSG_SHORT       // pad length beyond the message
    } t_msg_kind;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    pku_in_if  in_if ();
    pku_out_if out_if ();

    pkcs7_unpad_checker u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_if),
        .o_out         (out_if),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Stimulus and scoreboard state
    t_in_req  byte_q[$];
    t_out_req awaited_q[$];
    int       n_queued    = 0;
    int       n_taken     = 0;
    int       n_errors    = 0;
    int       quiet_cycles = 0;
    bit       in_gaps      = 1'b0;
    int       out_stall_max = 0;
    logic     in_fire  = 1'b0;
    logic     out_fire = 1'b0;

    // Mirror of the block's hold buffer and register
    logic [BYTE_W-1:0] mir_held [HOLD_DEPTH];
    int                mir_count = 0;
    logic [CFG_W-1:0]  mir_block = BLOCK_SIZE_RST;

    task automatic report_mismatch(input string what);
        n_errors++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Work out the requests one accepted byte causes
    task automatic unpad_predict(input logic [BYTE_W-1:0] b, input logic last);
        int  lim;
        int  bsz;
        int  x;
        int  start;
        bit  ok;
        bsz = int'(mir_block);
        lim = (bsz < 1) ? 0 : ((bsz > MAX_BLOCK) ? MAX_BLOCK - 1 : bsz - 1);
        if (!last) begin
            if (mir_count < lim) begin
                mir_held[mir_count] = b;
                mir_count++;
            end else if (mir_count == 0) begin
                awaited_q.push_back('{data: b, eom: 1'b0, ok: 1'b0});
            end else begin
                // oldest byte leaves, new byte joins at the young end
                awaited_q.push_back('{data: mir_held[0], eom: 1'b0, ok: 1'b0});
                for (int i = 0; i < mir_count - 1; i++)
                    mir_held[i] = mir_held[i + 1];
                mir_held[mir_count - 1] = b;
            end
        end else begin
            x     = int'(b);
            ok    = 1'b1;
            start = 0;
            if (x == 0 || x > bsz || x > mir_count + 1) begin
                ok = 1'b0;
            end else begin
                start = mir_count + 1 - x;
                for (int i = start; i < mir_count; i++)
                    if (mir_held[i] != b)
                        ok = 1'b0;
            end
            if (ok)
                for (int i = 0; i < start; i++)
                    awaited_q.push_back('{data: mir_held[i], eom: 1'b0, ok: 1'b0});
            awaited_q.push_back('{data: '0, eom: 1'b1, ok: ok});
            mir_count = 0;
        end
    endtask

    task automatic queue_byte(input logic [BYTE_W-1:0] b, input logic last);
        t_in_req r;
        r.data = b;
        r.last = last;
        r.gap  = in_gaps ? $urandom_range(0, GAP_MAX) : 0;
        byte_q.push_back(r);
        n_queued++;
    endtask

    // Data bytes, then n_pad bytes of pad_val, the last one flagged final
    task automatic queue_message(input int n_data, input int n_pad,
                                 input logic [BYTE_W-1:0] pad_val, input bit spoil);
        int bad_at;
        bad_at = (spoil && n_pad > 1) ? $urandom_range(0, n_pad - 2) : -1;
        for (int i = 0; i < n_data; i++)
            queue_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
        for (int i = 0; i < n_pad - 1; i++)
            queue_byte((i == bad_at) ? pad_val ^ BYTE_W'($urandom_range(1, 255)) : pad_val,
                       1'b0);
        queue_byte(pad_val, 1'b1);
    endtask

    task automatic queue_random_message(input int bsz);
        int          eff;
        int          roll;
        int          n_data;
        int          n_pad;
        logic [BYTE_W-1:0] pv;
        t_msg_kind   kind;
        eff    = (bsz < 1) ? 1 : ((bsz > MAX_BLOCK) ? MAX_BLOCK : bsz);
        n_data = $urandom_range(0, 2 * eff + 2);
        roll   = $urandom_range(0, 9);
        kind   = (roll < 7) ? MSG_GOOD : (roll == 7) ? MSG_SPOILT :
                 (roll == 8) ? MSG_BAD_VALUE : MSG_SHORT;
        n_pad  = $urandom_range(1, eff);
        case (kind)
            MSG_GOOD: begin
                queue_message(n_data, n_pad, BYTE_W'(n_pad), 1'b0);
            end
            MSG_SPOILT: begin
                queue_message(n_data, n_pad, BYTE_W'(n_pad), 1'b1);
            end
            MSG_BAD_VALUE: begin
                case ($urandom_range(0, 2))
                    0:       pv = '0;
                    1:       pv = BYTE_W'($urandom_range(bsz + 1, 255));
                    default: pv = BYTE_W'($urandom_range(0, 255));
                endcase
                queue_message(n_data, n_pad, pv, 1'b0);
            end
            default: begin
                // fewer bytes in the message than the pad length claims
                pv = BYTE_W'($urandom_range(2, eff + 1));
                queue_message(0, $urandom_range(1, int'(pv) - 1), pv, 1'b0);
            end
        endcase
    endtask

    task automatic wait_drain();
        while (n_taken != n_queued || awaited_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register writes only once the block has gone quiet
    task automatic set_block_size(input int v);
        wait_drain();
        @(negedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CFG_W'(v);
        @(negedge i_clk);
        cfg_wr_en   <= 1'b0;
        mir_block = CFG_W'(v);
    endtask

    // Input driver: one request at a time from byte_q, with its gap first
    int gap_done = 0;
    always @(negedge i_clk) begin
        logic vld_next;
        vld_next = in_if.valid;
        if (i_rst_n && (!in_if.valid || in_fire)) begin
            vld_next = 1'b0;
            if (byte_q.size() > 0) begin
                if (gap_done < byte_q[0].gap) begin
                    gap_done++;
                end else begin
                    in_if.in_byte <= byte_q[0].data;
                    in_if.in_last <= byte_q[0].last;
                    void'(byte_q.pop_front());
                    vld_next = 1'b1;
                    gap_done = 0;
                end
            end
        end
        in_if.valid <= vld_next;
    end

    // Output back-pressure: a fresh stall drawn after every accepted request
    int stall_left = 0;
    always @(negedge i_clk) begin
        logic rdy_next;
        rdy_next = out_if.ready;
        if (!i_rst_n) begin
            rdy_next = 1'b0;
        end else begin
            if (out_fire)
                stall_left = (out_stall_max > 0) ? $urandom_range(0, out_stall_max) : 0;
            if (!out_if.ready || out_fire) begin
                if (stall_left > 0) begin
                    stall_left--;
                    rdy_next = 1'b0;
                end else begin
                    rdy_next = 1'b1;
                end
            end
        end
        out_if.ready <= rdy_next;
    end

    // Monitor: predict on accepted input, check accepted output, watchdog
    always @(posedge i_clk) begin
        t_out_req got;
        t_out_req want;
        if (!i_rst_n) begin
            in_fire  <= 1'b0;
            out_fire <= 1'b0;
            quiet_cycles = 0;
        end else begin
            in_fire  <= in_if.valid && in_if.ready;
            out_fire <= out_if.valid && out_if.ready;
            if (in_if.valid && in_if.ready) begin
                unpad_predict(in_if.in_byte, in_if.in_last);
                n_taken++;
            end
            if (out_if.valid && out_if.ready) begin
                got = '{data: out_if.out_byte, eom: out_if.end_of_message,
                        ok: out_if.pad_valid};
                if (awaited_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected request byte=%02h eom=%0b pad_valid=%0b",
                                              got.data, got.eom, got.ok));
                end else begin
                    want = awaited_q.pop_front();
                    if (got.data != want.data)
                        report_mismatch($sformatf("out_byte %02h, wanted %02h",
                                                  got.data, want.data));
                    if (got.eom != want.eom)
                        report_mismatch($sformatf("end_of_message %0b, wanted %0b",
                                                  got.eom, want.eom));
                    if (got.ok != want.ok)
                        report_mismatch($sformatf("pad_valid %0b, wanted %0b",
                                                  got.ok, want.ok));
                end
            end
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[%0t] timeout: no request accepted for %0d cycles",
                         $time, quiet_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Sequence of phases
    initial begin
        int phase_size [8];
        int start_items;
        in_if.valid   = 1'b0;
        in_if.in_byte = '0;
        in_if.in_last = 1'b0;
        out_if.ready  = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        i_rst_n       = 1'b0;
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset block size, data extremes and a two-byte pad
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_message(0, 2, 8'd2, 1'b0);

        // Small block: zero pad, pad over block size, pad over length,
        // full-block pad, altered pad byte
        set_block_size(4);
        queue_message(0, 1, 8'd0, 1'b0);
        queue_message(1, 1, 8'd5, 1'b0);
        queue_message(0, 1, 8'd3, 1'b0);
        queue_message(0, 4, 8'd4, 1'b0);
        queue_message(1, 3, 8'd3, 1'b1);

        // Block size zero: bytes pass straight through, every pad fails
        set_block_size(0);
        queue_message(1, 1, 8'd1, 1'b0);

        // Block size above the largest supported: limited by held bytes
        set_block_size(63);
        queue_message(0, 1, 8'd33, 1'b0);

        // Block size lowered with bytes still held
        set_block_size(8);
        for (int i = 0; i < 5; i++)
            queue_byte(8'($urandom_range(0, 255)), 1'b0);
        set_block_size(2);
        queue_message(1, 1, 8'd1, 1'b0);

        // Random phases over extreme and ordinary block sizes
        phase_size = '{1, 32, 63, 0, 0, 0, 0, 16};
        phase_size[4] = $urandom_range(2, 31);
        phase_size[5] = $urandom_range(2, 31);
        phase_size[6] = $urandom_range(33, 62);
        for (int p = 0; p < 8; p++) begin
            set_block_size(phase_size[p]);
            in_gaps       = (p % 4 == 0) || (p % 4 == 2);
            out_stall_max = ((p % 4 == 0) || (p % 4 == 3)) ? GAP_MAX : 0;
            start_items   = n_queued;
            while (n_queued - start_items < PHASE_ITEMS)
                queue_random_message(phase_size[p]);
        end

        wait_drain();
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
